// ===== sv/pcbd_pkg.sv =====
package pcbd_pkg;

    localparam int MAX_PULSES = 16;

    localparam int SHUT_W   = 12;
    localparam int TICK_W   = 8;
    localparam int BRIGHT_W = 8;
    localparam int CNT_W    = 12;
    localparam int PULSE_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int BRIGHT_MAX = 100;
    // width of clamped brightness times MAX_PULSES
    localparam int PROD_W = $clog2(BRIGHT_MAX * MAX_PULSES + 1);

    localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW        = 2'd3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_SHUTDOWN = 2'd1;
    localparam logic [1:0] PH_LOW      = 2'd2;
    localparam logic [1:0] PH_HIGH     = 2'd3;

    localparam logic [SHUT_W-1:0] SHUT_RST       = SHUT_W'(2600);
    localparam logic [TICK_W-1:0] FIRST_HIGH_RST = TICK_W'(20);
    localparam logic [TICK_W-1:0] HIGH_RST       = TICK_W'(1);
    localparam logic [TICK_W-1:0] LOW_RST        = TICK_W'(1);

    typedef struct packed {
        logic [SHUT_W-1:0] shutdown;
        logic [TICK_W-1:0] first_high;
        logic [TICK_W-1:0] high;
        logic [TICK_W-1:0] low;
    } t_cfg;

    typedef struct packed {
        logic pin;
        logic busy;
    } t_status;

endpackage

// ===== sv/pcbd_seq.sv =====
module pcbd_seq
    import pcbd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_command,
    input  logic [BRIGHT_W-1:0] i_brightness,
    input  t_cfg                i_cfg,
    output t_status             o_cur,
    output t_status             o_next
);

    logic [1:0]         r_phase,   n_phase;
    logic [CNT_W-1:0]   r_cnt,     n_cnt;
    logic [PULSE_W-1:0] r_pulses,  n_pulses;
    logic               r_first,   n_first;
    logic               r_pin,     n_pin;

    logic [BRIGHT_W-1:0] clamped;
    logic [PROD_W-1:0]   prod;
    logic [PULSE_W-1:0]  ceil_q;
    logic [PULSE_W-1:0]  set_pulses;
    logic [PULSE_W-1:0]  base_pulses;
    logic [PULSE_W-1:0]  dec_pulses;
    logic [CNT_W-1:0]    dec_cnt;
    logic [TICK_W-1:0]   high_sel;
    logic [CNT_W-1:0]    low_len;
    logic [CNT_W-1:0]    high_len;

    // ceil(b * MAX_PULSES / 100) as a count of exceeded thresholds; the compares
    // form a thermometer code, so the highest one exceeded gives the count
    always_comb begin
        clamped = (i_brightness > BRIGHT_W'(BRIGHT_MAX)) ? BRIGHT_W'(BRIGHT_MAX) : i_brightness;
        prod    = PROD_W'(clamped) * PROD_W'(MAX_PULSES);
        ceil_q  = '0;
        for (int k = 0; k < MAX_PULSES; k++) begin
            if (prod > PROD_W'(k * BRIGHT_MAX)) begin
                ceil_q = PULSE_W'(k + 1);
            end
        end
        set_pulses = (ceil_q == '0) ? '0 : PULSE_W'(MAX_PULSES + 1) - ceil_q;
    end

    always_comb begin
        high_sel = r_first ? i_cfg.first_high : i_cfg.high;
        low_len  = (i_cfg.low == '0) ? CNT_W'(1) : CNT_W'(i_cfg.low);
        high_len = (high_sel == '0) ? CNT_W'(1) : CNT_W'(high_sel);
        dec_cnt  = (r_cnt != '0) ? r_cnt - CNT_W'(1) : r_cnt;

        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_pulses = r_pulses;
        n_first  = r_first;
        n_pin    = r_pin;

        base_pulses = (i_command == CMD_SET) ? set_pulses : r_pulses;
        dec_pulses  = r_pulses - PULSE_W'(1);

        if (i_step) begin
            if (i_command == CMD_SET) begin
                n_pulses = set_pulses;
                n_first  = 1'b1;
                n_pin    = 1'b0;
                if (i_cfg.shutdown == '0) begin
                    if (base_pulses == '0) begin
                        n_phase = PH_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_phase = PH_LOW;
                        n_cnt   = low_len;
                    end
                end else begin
                    n_phase = PH_SHUTDOWN;
                    n_cnt   = i_cfg.shutdown;
                end
            end else if (r_phase != PH_IDLE) begin
                n_cnt = dec_cnt;
                if (dec_cnt == '0) begin
                    unique case (r_phase)
                        PH_SHUTDOWN: begin
                            if (r_pulses == '0) begin
                                n_phase = PH_IDLE;
                                n_pin   = 1'b0;
                                n_cnt   = '0;
                            end else begin
                                n_phase = PH_LOW;
                                n_pin   = 1'b0;
                                n_cnt   = low_len;
                            end
                        end
                        PH_LOW: begin
                            n_phase = PH_HIGH;
                            n_pin   = 1'b1;
                            n_cnt   = high_len;
                            n_first = 1'b0;
                        end
                        PH_HIGH: begin
                            n_pulses = dec_pulses;
                            if (dec_pulses == '0) begin
                                n_phase = PH_IDLE;
                                n_pin   = 1'b1;
                                n_cnt   = '0;
                            end else begin
                                n_phase = PH_LOW;
                                n_pin   = 1'b0;
                                n_cnt   = low_len;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cnt    <= '0;
            r_pulses <= '0;
            r_first  <= 1'b1;
            r_pin    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_pulses <= n_pulses;
            r_first  <= n_first;
            r_pin    <= n_pin;
        end
    end

    assign o_cur.pin   = r_pin;
    assign o_cur.busy  = (r_phase != PH_IDLE);
    assign o_next.pin  = n_pin;
    assign o_next.busy = (n_phase != PH_IDLE);

endmodule

// ===== sv/pulse_count_backlight_dimmer.sv =====
// Enable-pin sequencer for a pulse-counting LED driver. Each input transaction is
// either a one-microsecond tick (tuser = 0) or a brightness set (tuser = 1, percent in
// tdata, clamped to 100). A set drives the pin low for shutdown_ticks ticks, then emits
// 16 - ceil(b*16/100) + 1 low/high pulses (none for brightness 0, pin left low) and
// leaves the pin high. Every input transaction yields exactly one output transaction
// carrying the pin level and a busy flag. One transaction per clock while the output
// is not stalled: the state update is a single registered step and the output register
// is refilled whenever it is empty or being drained. Config writes are accepted at once.
module pulse_count_backlight_dimmer
    import pcbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] brightness
    input  logic                  s_axis_tuser,   // [0] command
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata    // [0] pin_level, [1] busy_res, [7:2] zero
);

    t_cfg    r_cfg;
    t_status cur_st;
    t_status next_st;
    logic    r_m_valid;
    t_status r_m_data;
    logic    s_accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shutdown   <= SHUT_RST;
            r_cfg.first_high <= FIRST_HIGH_RST;
            r_cfg.high       <= HIGH_RST;
            r_cfg.low        <= LOW_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SHUTDOWN:   r_cfg.shutdown   <= i_cfg_data[SHUT_W-1:0];
                REG_FIRST_HIGH: r_cfg.first_high <= i_cfg_data[TICK_W-1:0];
                REG_HIGH:       r_cfg.high       <= i_cfg_data[TICK_W-1:0];
                REG_LOW:        r_cfg.low        <= i_cfg_data[TICK_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    pcbd_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (s_accept),
        .i_command    (s_axis_tuser),
        .i_brightness (s_axis_tdata[BRIGHT_W-1:0]),
        .i_cfg        (r_cfg),
        .o_cur        (cur_st),
        .o_next       (next_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m_data <= next_st;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_m_data.busy, r_m_data.pin};

    // a set with a nonzero shutdown time always reports busy
    a_set_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && s_axis_tuser == CMD_SET && r_cfg.shutdown != '0 |=> m_axis_tdata[1])
        else $error("set with shutdown time did not report busy");

    // brightness zero never raises the pin on the set transaction
    a_zero_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && s_axis_tuser == CMD_SET && s_axis_tdata == 8'd0 |=> !m_axis_tdata[0])
        else $error("brightness zero drove the pin high");

    // a tick while idle leaves the pin and busy flag alone
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && s_axis_tuser == CMD_TICK && !cur_st.busy
        |=> m_axis_tdata[0] == $past(cur_st.pin) && !m_axis_tdata[1])
        else $error("idle tick changed the pin state");

endmodule

// ===== tb/sv/tb_pulse_count_backlight_dimmer.sv =====
module tb_pulse_count_backlight_dimmer;
    timeunit 1ns;
    timeprecision 1ps;

    import pcbd_pkg::*;

    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 1650;
    localparam int PHASE_ITEMS    = 120;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} t_stim_kind;

    typedef struct packed {
        t_stim_kind            kind;
        logic                  cmd;
        logic [BRIGHT_W-1:0]   bright;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_stim_op;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [7:0] brightness
    logic                  s_axis_tuser  = 1'b0; // [0] command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;         // [0] pin_level, [1] busy_res, [7:2] zero

    pulse_count_backlight_dimmer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // pending stimulus and expected pin status
    t_stim_op op_q[$];
    t_status  pin_status_q[$];
    int       items_queued = 0;
    int       fail_cnt     = 0;

    // sequencer model
    t_cfg               cfg_model;
    logic [1:0]         seq_phase;
    logic [CNT_W-1:0]   ticks_to_go;
    logic [PULSE_W-1:0] pulses_to_go;
    logic               on_first_pulse;
    logic               pin_model;

    // settings as the generator sees them, used to size the tick runs
    t_cfg gen_cfg;

    function automatic logic [CNT_W-1:0] ticks_or_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? CNT_W'(1) : CNT_W'(v);
    endfunction

    function automatic int pause_len(input bit steady);
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic void flag_error(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endfunction

    function automatic void start_low_span();
        seq_phase   = PH_LOW;
        pin_model   = 1'b0;
        ticks_to_go = ticks_or_one(cfg_model.low);
    endfunction

    function automatic void finish_shutdown();
        if (pulses_to_go == '0) begin
            seq_phase   = PH_IDLE;
            pin_model   = 1'b0;
            ticks_to_go = '0;
        end else begin
            start_low_span();
        end
    endfunction

    function automatic void step_pin_sequencer(input logic cmd, input logic [BRIGHT_W-1:0] bright);
        int      pct;
        int      steps;
        t_status res;
        if (cmd == CMD_SET) begin
            pct   = (bright > BRIGHT_MAX) ? BRIGHT_MAX : int'(bright);
            steps = (pct * MAX_PULSES + BRIGHT_MAX - 1) / BRIGHT_MAX;
            // brightness 0 gives no pulses at all
            pulses_to_go   = (steps == 0) ? '0 : PULSE_W'(MAX_PULSES - steps + 1);
            on_first_pulse = 1'b1;
            pin_model      = 1'b0;
            if (cfg_model.shutdown == '0) begin
                finish_shutdown();
            end else begin
                seq_phase   = PH_SHUTDOWN;
                ticks_to_go = CNT_W'(cfg_model.shutdown);
            end
        end else if (seq_phase != PH_IDLE) begin
            if (ticks_to_go != '0)
                ticks_to_go = ticks_to_go - CNT_W'(1);
            if (ticks_to_go == '0) begin
                case (seq_phase)
                    PH_SHUTDOWN: begin
                        finish_shutdown();
                    end
                    PH_LOW: begin
                        seq_phase      = PH_HIGH;
                        pin_model      = 1'b1;
                        ticks_to_go    = ticks_or_one(on_first_pulse ? cfg_model.first_high
                                                                     : cfg_model.high);
                        on_first_pulse = 1'b0;
                    end
                    PH_HIGH: begin
                        pulses_to_go = pulses_to_go - PULSE_W'(1);
                        if (pulses_to_go == '0) begin
                            seq_phase   = PH_IDLE;
                            pin_model   = 1'b1;
                            ticks_to_go = '0;
                        end else begin
                            start_low_span();
                        end
                    end
                    default: ;
                endcase
            end
        end
        res.pin  = pin_model;
        res.busy = (seq_phase != PH_IDLE);
        pin_status_q.push_back(res);
    endfunction

    // ---------------- stimulus generation ----------------

    function automatic void queue_item(input logic cmd, input logic [BRIGHT_W-1:0] bright);
        t_stim_op op;
        op        = '0;
        op.kind   = OP_ITEM;
        op.cmd    = cmd;
        op.bright = bright;
        op_q.push_back(op);
        items_queued++;
    endfunction

    function automatic void queue_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        t_stim_op op;
        op      = '0;
        op.kind = OP_CFG;
        op.idx  = idx;
        op.data = data;
        op_q.push_back(op);
    endfunction

    function automatic void queue_drain();
        t_stim_op op;
        op      = '0;
        op.kind = OP_DRAIN;
        op_q.push_back(op);
    endfunction

    // upper data bits of the 8-bit registers carry junk, the block must drop them
    function automatic void queue_settings(input logic [SHUT_W-1:0] sd, input logic [TICK_W-1:0] fh,
                                           input logic [TICK_W-1:0] hi, input logic [TICK_W-1:0] lo);
        queue_drain();
        queue_write(REG_SHUTDOWN, CFG_DATA_W'(sd));
        queue_write(REG_FIRST_HIGH, {4'($urandom_range(0, 15)), fh});
        queue_write(REG_HIGH, {4'($urandom_range(0, 15)), hi});
        queue_write(REG_LOW, {4'($urandom_range(0, 15)), lo});
        gen_cfg.shutdown   = sd;
        gen_cfg.first_high = fh;
        gen_cfg.high       = hi;
        gen_cfg.low        = lo;
    endfunction

    // one set followed by ticks: mostly a full run, sometimes cut short by the next set
    function automatic void queue_run(input logic [BRIGHT_W-1:0] bright);
        int pct;
        int pulses;
        int span_len;
        int n;
        pct      = (bright > BRIGHT_MAX) ? BRIGHT_MAX : int'(bright);
        pulses   = (pct * MAX_PULSES + BRIGHT_MAX - 1) / BRIGHT_MAX;
        pulses   = (pulses == 0) ? 0 : MAX_PULSES - pulses + 1;
        span_len = int'(gen_cfg.shutdown);
        if (pulses != 0)
            span_len += pulses * int'(ticks_or_one(gen_cfg.low))
                      + int'(ticks_or_one(gen_cfg.first_high))
                      + (pulses - 1) * int'(ticks_or_one(gen_cfg.high));
        if (span_len > 600)
            n = $urandom_range(0, 200);
        else if ($urandom_range(0, 3) == 0)
            n = $urandom_range(0, span_len);
        else
            n = span_len + $urandom_range(0, 3);
        queue_item(CMD_SET, bright);
        repeat (n) queue_item(CMD_TICK, 8'($urandom));
    endfunction

    function automatic logic [BRIGHT_W-1:0] pick_brightness();
        case ($urandom_range(0, 9))
            0, 1:    return 8'($urandom);
            2:       return 8'd0;
            3:       return 8'($urandom_range(100, 255));
            default: return 8'($urandom_range(1, 100));
        endcase
    endfunction

    // ---------------- input side ----------------

    logic     in_fire, cfg_fire, in_valid_nxt, cfg_valid_nxt;
    bit       feeding   = 1'b0;
    bit       tx_steady = 1'b0;
    int       gap_left  = 0;
    int       drain_wait = 0;
    t_stim_op head_op;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid       <= 1'b0;
            i_cfg_valid         <= 1'b0;
            feeding             = 1'b0;
            gap_left            = 0;
            drain_wait          = 0;
            cfg_model.shutdown   = SHUT_RST;
            cfg_model.first_high = FIRST_HIGH_RST;
            cfg_model.high       = HIGH_RST;
            cfg_model.low        = LOW_RST;
            seq_phase           = PH_IDLE;
            ticks_to_go         = '0;
            pulses_to_go        = '0;
            on_first_pulse      = 1'b1;
            pin_model           = 1'b0;
        end else begin
            in_fire       = s_axis_tvalid && s_axis_tready;
            cfg_fire      = i_cfg_valid && o_cfg_ready;
            in_valid_nxt  = s_axis_tvalid && !in_fire;
            cfg_valid_nxt = i_cfg_valid && !cfg_fire;
            if (in_fire)
                step_pin_sequencer(s_axis_tuser, s_axis_tdata);
            if (cfg_fire) begin
                case (i_cfg_index)
                    REG_SHUTDOWN:   cfg_model.shutdown   = i_cfg_data[SHUT_W-1:0];
                    REG_FIRST_HIGH: cfg_model.first_high = i_cfg_data[TICK_W-1:0];
                    REG_HIGH:       cfg_model.high       = i_cfg_data[TICK_W-1:0];
                    REG_LOW:        cfg_model.low        = i_cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end
            if (in_fire || cfg_fire) begin
                feeding = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    tx_steady = !tx_steady;
                gap_left = pause_len(tx_steady);
            end
            if (!feeding && op_q.size() != 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    head_op = op_q[0];
                    case (head_op.kind)
                        OP_ITEM: begin
                            s_axis_tuser <= head_op.cmd;
                            s_axis_tdata <= head_op.bright;
                            in_valid_nxt = 1'b1;
                            feeding      = 1'b1;
                            void'(op_q.pop_front());
                        end
                        OP_CFG: begin
                            i_cfg_index   <= head_op.idx;
                            i_cfg_data    <= head_op.data;
                            cfg_valid_nxt = 1'b1;
                            feeding       = 1'b1;
                            void'(op_q.pop_front());
                        end
                        default: begin
                            // hold off until every pending result is back, then settle
                            drain_wait = (pin_status_q.size() == 0) ? drain_wait + 1 : 0;
                            if (drain_wait >= SETTLE_CYCLES) begin
                                drain_wait = 0;
                                void'(op_q.pop_front());
                            end
                        end
                    endcase
                end
            end
            s_axis_tvalid <= in_valid_nxt;
            i_cfg_valid   <= cfg_valid_nxt;
        end
    end

    // ---------------- output side ----------------

    bit      rx_steady  = 1'b0;
    int      stall_left = 0;
    t_status want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pin_status_q.size() == 0) begin
                    flag_error($sformatf("result with nothing pending, tdata=%h", m_axis_tdata));
                end else begin
                    want = pin_status_q.pop_front();
                    if (m_axis_tdata[0] !== want.pin)
                        flag_error($sformatf("pin_level expected %b got %b",
                                             want.pin, m_axis_tdata[0]));
                    if (m_axis_tdata[1] !== want.busy)
                        flag_error($sformatf("busy_res expected %b got %b",
                                             want.busy, m_axis_tdata[1]));
                    if (m_axis_tdata[7:2] !== 6'd0)
                        flag_error($sformatf("padding expected 0 got %b", m_axis_tdata[7:2]));
                end
                if ($urandom_range(0, 39) == 0)
                    rx_steady = !rx_steady;
                stall_left = pause_len(rx_steady);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_axis_tready <= (stall_left == 0);
        end
    end

    // ---------------- watchdog ----------------

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- sequence ----------------

    initial begin : stimulus
        int phase_end;
        gen_cfg.shutdown   = SHUT_RST;
        gen_cfg.first_high = FIRST_HIGH_RST;
        gen_cfg.high       = HIGH_RST;
        gen_cfg.low        = LOW_RST;

        // reset settings: ticks while idle, then a set restarted during shutdown
        queue_item(CMD_TICK, 8'hFF);
        queue_item(CMD_TICK, 8'h00);
        queue_item(CMD_SET, 8'd100);
        repeat (3) queue_item(CMD_TICK, 8'($urandom));
        queue_item(CMD_SET, 8'd0);
        repeat (2) queue_item(CMD_TICK, 8'($urandom));

        // zero times behave as one tick, zero shutdown acts on the set itself
        queue_settings(12'd0, 8'd0, 8'd0, 8'd0);
        queue_item(CMD_SET, 8'd0);
        queue_item(CMD_TICK, 8'($urandom));
        queue_item(CMD_SET, 8'd255);
        repeat (3) queue_item(CMD_TICK, 8'($urandom));
        queue_item(CMD_SET, 8'd101);
        repeat (2) queue_item(CMD_TICK, 8'($urandom));
        queue_item(CMD_SET, 8'd93);
        repeat (4) queue_item(CMD_TICK, 8'($urandom));
        queue_run(8'd1);
        queue_run(8'd94);

        queue_settings(12'd4095, 8'd255, 8'd255, 8'd255);
        queue_run(8'd100);
        queue_run(8'd50);
        queue_settings(12'd0, 8'd255, 8'd255, 8'd255);
        queue_run(8'd100);

        while (items_queued < ITEM_TARGET) begin
            if ($urandom_range(0, 5) == 0)
                queue_settings($urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(0, 4095)),
                               8'($urandom), 8'($urandom), 8'($urandom));
            else
                queue_settings(12'($urandom_range(0, 24)), 8'($urandom_range(0, 8)),
                               8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)));
            phase_end = items_queued + PHASE_ITEMS;
            while (items_queued < phase_end) begin
                queue_run(pick_brightness());
                if ($urandom_range(0, 15) == 0)
                    queue_drain();
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_q.size() != 0 || feeding || pin_status_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0 && pin_status_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
